[design/packet_fifo_dedup_range_count_defines.svh]
// assertion helpers used by the packet fifo top file
`ifndef PACKET_FIFO_DEDUP_RANGE_COUNT_DEFINES_SVH
`define PACKET_FIFO_DEDUP_RANGE_COUNT_DEFINES_SVH

// property that must hold on every clock outside reset
`define PFDRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a consequence in the next
`define PFDRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pfdrc_pkg.sv]
package pfdrc_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);
    localparam int CAP_W      = 7;
    localparam int LIM_W      = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int CNT_OUT_W  = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_FWD   = 2'd1;
    localparam logic [1:0] CMD_COUNT = 2'd2;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [OCC_W-1:0] t_occ;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] source;
        logic [15:0] destination;
        logic [29:0] timestamp;
        logic [29:0] start_time;
        logic [29:0] end_time;
    } t_req;

    typedef struct packed {
        logic                 accepted;
        logic                 packet_valid;
        logic [15:0]          out_source;
        logic [15:0]          out_destination;
        logic [29:0]          out_timestamp;
        logic [CNT_OUT_W-1:0] match_count;
    } t_rsp;

    // one stored packet
    typedef struct packed {
        logic [15:0] source;
        logic [15:0] destination;
        logic [29:0] timestamp;
    } t_pkt;

    localparam int PKT_W = $bits(t_pkt);

    typedef struct packed {
        logic start;
        logic cmp_en;
    } t_scan_ctl;

    typedef struct packed {
        logic dup;
        t_occ count;
        t_pkt pkt;
    } t_scan_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // ring pointer advanced by an offset of at most one full lap
    function automatic t_ptr wrap_add(input t_ptr ptr, input t_occ off);
        logic [OCC_W:0] sum;
        sum = (OCC_W + 1)'(ptr) + (OCC_W + 1)'(off);
        if (sum >= (OCC_W + 1)'(FIFO_DEPTH)) begin
            sum = sum - (OCC_W + 1)'(FIFO_DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    // zero acts as one, anything above the depth acts as the depth
    function automatic t_occ eff_limit(input logic [CAP_W-1:0] cap);
        logic [LIM_W-1:0] lim;
        lim = LIM_W'(cap);
        if (lim == '0) begin
            lim = LIM_W'(1);
        end else if (lim > LIM_W'(FIFO_DEPTH)) begin
            lim = LIM_W'(FIFO_DEPTH);
        end
        return OCC_W'(lim);
    endfunction

endpackage

[design/pfdrc_ram.sv]
module pfdrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/pfdrc_scan.sv]
module pfdrc_scan import pfdrc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_ctl i_ctl,
    input  t_req      i_req,
    input  t_pkt      i_rdata,
    output t_scan_res o_res
);

    logic r_dup;
    logic n_dup;
    t_occ r_count;
    t_occ n_count;
    t_pkt r_pkt;
    t_pkt n_pkt;
    logic hit_dup;
    logic hit_range;

    always_comb begin
        hit_dup   = (i_rdata.source == i_req.source)
                 && (i_rdata.destination == i_req.destination)
                 && (i_rdata.timestamp == i_req.timestamp);
        // an inverted window never matches since both bounds must hold
        hit_range = (i_rdata.destination == i_req.destination)
                 && (i_rdata.timestamp >= i_req.start_time)
                 && (i_rdata.timestamp <= i_req.end_time);
    end

    always_comb begin
        n_dup   = r_dup;
        n_count = r_count;
        n_pkt   = r_pkt;
        if (i_ctl.start) begin
            n_dup   = 1'b0;
            n_count = '0;
        end else if (i_ctl.cmp_en) begin
            n_dup   = r_dup | hit_dup;
            n_count = r_count + OCC_W'(hit_range);
            n_pkt   = i_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dup   <= 1'b0;
            r_count <= '0;
        end else begin
            r_dup   <= n_dup;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt <= n_pkt;
    end

    assign o_res.dup   = r_dup;
    assign o_res.count = r_count;
    assign o_res.pkt   = r_pkt;

endmodule

[design/packet_fifo_dedup_range_count.sv]
// a new request is taken only in the idle state; add and count read every held entry,
//   forward of a held packet reads only the head entry, other requests read nothing
// the next request waits until the result of the last is loaded at the output, so
//   the scan by the single read port over each held entry sets the request rate
// reset: head, tail and occupancy go to zero, the limit to 64; the packet
//   memory is not cleared, only held entries are ever read
`include "packet_fifo_dedup_range_count_defines.svh"

module packet_fifo_dedup_range_count import pfdrc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_req             i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_rsp             o_out,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data
);

    t_state           r_state;
    t_state           n_state;
    t_req             r_req;
    t_req             n_req;
    t_ptr             r_head;
    t_ptr             n_head;
    t_ptr             r_tail;
    t_ptr             n_tail;
    t_occ             r_occ;
    t_occ             n_occ;
    logic [CAP_W-1:0] r_cap;
    t_occ             r_scan_len;
    t_occ             n_scan_len;
    t_occ             r_issue;
    t_occ             n_issue;
    t_ptr             r_slot;
    t_ptr             n_slot;
    logic             r_cmp_vld;
    logic             n_cmp_vld;
    logic             r_out_valid;
    logic             n_out_valid;
    t_rsp             r_out;
    t_rsp             n_out;

    logic             out_free;
    logic             rd_en;
    logic             wr_en;
    t_pkt             wr_data;
    t_pkt             rd_data;
    t_occ             lim;
    t_scan_ctl        scan_ctl;
    t_scan_res        scan_res;

    assign out_free = !r_out_valid || !i_out_stall;
    assign lim      = eff_limit(r_cap);

    assign wr_data.source      = r_req.source;
    assign wr_data.destination = r_req.destination;
    assign wr_data.timestamp   = r_req.timestamp;

    pfdrc_ram #(
        .WIDTH (PKT_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_tail),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (r_slot),
        .o_rdata (rd_data)
    );

    pfdrc_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_req   (r_req),
        .i_rdata (rd_data),
        .o_res   (scan_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_issue == r_scan_len && !r_cmp_vld) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_req       = r_req;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_scan_len  = r_scan_len;
        n_issue     = r_issue;
        n_slot      = r_slot;
        n_cmp_vld   = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        scan_ctl    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req          = i_in;
                    n_slot         = r_head;
                    n_issue        = '0;
                    scan_ctl.start = 1'b1;
                    case (i_in.command)
                        CMD_ADD:   n_scan_len = r_occ;
                        CMD_COUNT: n_scan_len = r_occ;
                        // forward reads only the head entry
                        CMD_FWD:   n_scan_len = (r_occ != '0) ? OCC_W'(1) : '0;
                        default:   n_scan_len = '0;
                    endcase
                end
            end
            S_SCAN: begin
                rd_en           = (r_issue != r_scan_len);
                n_cmp_vld       = rd_en;
                scan_ctl.cmp_en = r_cmp_vld;
                if (rd_en) begin
                    n_slot  = wrap_add(r_slot, OCC_W'(1));
                    n_issue = r_issue + OCC_W'(1);
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    case (r_req.command)
                        CMD_ADD: begin
                            if (!scan_res.dup) begin
                                wr_en          = 1'b1;
                                n_out.accepted = 1'b1;
                                n_tail         = wrap_add(r_tail, OCC_W'(1));
                                // evict oldest entries down to one below the limit
                                if (r_occ >= lim) begin
                                    n_head = wrap_add(r_head, r_occ - lim + OCC_W'(1));
                                    n_occ  = lim;
                                end else begin
                                    n_occ  = r_occ + OCC_W'(1);
                                end
                            end
                        end
                        CMD_FWD: begin
                            if (r_occ != '0) begin
                                n_out.packet_valid    = 1'b1;
                                n_out.out_source      = scan_res.pkt.source;
                                n_out.out_destination = scan_res.pkt.destination;
                                n_out.out_timestamp   = scan_res.pkt.timestamp;
                                n_head                = wrap_add(r_head, OCC_W'(1));
                                n_occ                 = r_occ - OCC_W'(1);
                            end
                        end
                        CMD_COUNT: begin
                            n_out.match_count = CNT_OUT_W'(scan_res.count);
                        end
                        default: begin
                            n_out = '0;
                        end
                    endcase
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_cap       <= CAP_RESET;
            r_scan_len  <= '0;
            r_issue     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_scan_len  <= n_scan_len;
            r_issue     <= n_issue;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_slot <= n_slot;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `PFDRC_ASSERT(a_occ_bound, r_occ <= OCC_W'(FIFO_DEPTH), "occupancy above fifo depth")
    `PFDRC_ASSERT(a_ptr_track, wrap_add(r_head, r_occ) == r_tail, "head tail and occupancy disagree")
    `PFDRC_ASSERT(a_no_rw_clash, !(rd_en && wr_en), "store read and written in one cycle")
    `PFDRC_ASSERT(a_issue_bound, r_issue <= r_scan_len, "scan issued past held entries")
    `PFDRC_ASSERT_NEXT(a_commit_load, r_state == S_COMMIT && out_free, o_out_valid, "commit did not load a result")

endmodule

[sim/packet_fifo_dedup_range_count_test.sv]
module packet_fifo_dedup_range_count_test import pfdrc_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam logic [29:0] TS_MAX     = 30'h3FFF_FFFF;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_req             i_in = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_rsp             o_out;
    logic             i_cfg_we = 1'b0;
    logic [CAP_W-1:0] i_cfg_data = '0;

    // mirror of the packet ring and the limit register
    t_pkt             held_pkts [FIFO_DEPTH];
    t_ptr             oldest_slot = '0;
    t_ptr             free_slot = '0;
    t_occ             held_count = '0;
    logic [CAP_W-1:0] limit_reg = CAP_RESET;

    t_rsp             expected_responses [$];
    logic [29:0]      ts_clock = '0;
    int unsigned      in_idle_pct = 0;
    int unsigned      out_stall_pct = 0;
    int unsigned      fail_count = 0;

    packet_fifo_dedup_range_count uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    function automatic t_ptr advance_slot(input t_ptr slot);
        return (slot == t_ptr'(FIFO_DEPTH - 1)) ? '0 : slot + 1'b1;
    endfunction

    function automatic t_rsp predict_response(input t_req req);
        t_rsp        rsp;
        t_ptr        slot;
        bit          dup;
        int unsigned lim;
        int unsigned hits;
        rsp = '0;
        slot = oldest_slot;
        case (req.command)
            CMD_ADD: begin
                dup = 1'b0;
                for (int k = 0; k < held_count; k++) begin
                    if (held_pkts[slot] == {req.source, req.destination, req.timestamp})
                        dup = 1'b1;
                    slot = advance_slot(slot);
                end
                if (!dup) begin
                    lim = (limit_reg == 0) ? 1 :
                          (limit_reg > FIFO_DEPTH) ? FIFO_DEPTH : limit_reg;
                    while (held_count >= lim) begin
                        oldest_slot = advance_slot(oldest_slot);
                        held_count--;
                    end
                    held_pkts[free_slot] = {req.source, req.destination, req.timestamp};
                    free_slot = advance_slot(free_slot);
                    held_count++;
                    rsp.accepted = 1'b1;
                end
            end
            CMD_FWD: begin
                if (held_count != 0) begin
                    rsp.packet_valid    = 1'b1;
                    rsp.out_source      = held_pkts[oldest_slot].source;
                    rsp.out_destination = held_pkts[oldest_slot].destination;
                    rsp.out_timestamp   = held_pkts[oldest_slot].timestamp;
                    oldest_slot = advance_slot(oldest_slot);
                    held_count--;
                end
            end
            CMD_COUNT: begin
                hits = 0;
                for (int k = 0; k < held_count; k++) begin
                    if (held_pkts[slot].destination == req.destination &&
                        held_pkts[slot].timestamp >= req.start_time &&
                        held_pkts[slot].timestamp <= req.end_time)
                        hits++;
                    slot = advance_slot(slot);
                end
                rsp.match_count = CNT_OUT_W'(hits);
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        if (fail_count <= 100)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_failure($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_response(input t_rsp got);
        t_rsp want;
        if (expected_responses.size() == 0) begin
            report_failure("result with no request pending");
        end else begin
            want = expected_responses.pop_front();
            compare_field("accepted", got.accepted, want.accepted);
            compare_field("packet_valid", got.packet_valid, want.packet_valid);
            compare_field("out_source", got.out_source, want.out_source);
            compare_field("out_destination", got.out_destination, want.out_destination);
            compare_field("out_timestamp", got.out_timestamp, want.out_timestamp);
            compare_field("match_count", got.match_count, want.match_count);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_response(o_out);
    end

    task automatic send_request(input t_req req);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_responses.insert(expected_responses.size(), predict_response(req));
    endtask

    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        while (expected_responses.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [CAP_W-1:0] value);
        wait_for_idle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_reg = value;
    endtask

    function automatic t_req make_req(input logic [1:0] cmd, input logic [15:0] src,
                                      input logic [15:0] dst, input logic [29:0] ts,
                                      input logic [29:0] t_lo, input logic [29:0] t_hi);
        t_req req;
        req.command     = cmd;
        req.source      = src;
        req.destination = dst;
        req.timestamp   = ts;
        req.start_time  = t_lo;
        req.end_time    = t_hi;
        return req;
    endfunction

    function automatic t_req random_request();
        t_req          req;
        logic [127:0]  noise;
        int unsigned   pick;
        int unsigned   idx;
        logic [29:0]   lo;
        logic [29:0]   span;
        noise = {$urandom(), $urandom(), $urandom(), $urandom()};
        req = noise[$bits(t_req)-1:0];
        pick = $urandom_range(99);
        if (pick < 8) begin
            // raw noise over every field, unused command included
            return req;
        end
        if (pick < 14 && held_count != 0) begin
            // resend a held packet, must be dropped as a duplicate
            idx = (oldest_slot + $urandom_range(held_count - 1)) % FIFO_DEPTH;
            req.command     = CMD_ADD;
            req.source      = held_pkts[idx].source;
            req.destination = held_pkts[idx].destination;
            req.timestamp   = held_pkts[idx].timestamp;
        end else if (pick < 52) begin
            if (ts_clock <= TS_MAX - 3)
                ts_clock = ts_clock + 30'($urandom_range(2));
            req.command     = CMD_ADD;
            req.source      = $urandom_range(1) ? req.source : 16'($urandom_range(3));
            req.destination = 16'($urandom_range(3));
            req.timestamp   = ts_clock;
        end else if (pick < 72) begin
            req.command = CMD_FWD;
        end else begin
            req.command     = CMD_COUNT;
            req.destination = 16'($urandom_range(3));
            span = 30'($urandom_range(40));
            lo   = (ts_clock > span) ? ts_clock - span : '0;
            span = 30'($urandom_range(40));
            req.start_time = lo;
            req.end_time   = (lo > TS_MAX - span) ? TS_MAX : lo + span;
            if ($urandom_range(9) == 0) begin
                req.start_time = req.end_time + 1'b1;
                req.end_time   = lo;
            end
        end
        return req;
    endfunction

    task automatic test_commands();
        send_request(make_req(CMD_FWD, 16'hFFFF, 16'hFFFF, TS_MAX, TS_MAX, TS_MAX));
        send_request(make_req(CMD_COUNT, 0, 0, 0, 0, TS_MAX));
        send_request(make_req(CMD_ADD, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_ADD, 16'hFFFF, 16'hFFFF, TS_MAX, TS_MAX, TS_MAX));
        send_request(make_req(CMD_ADD, 0, 0, 0, TS_MAX, TS_MAX));
        send_request(make_req(CMD_ADD, 0, 0, 1, 0, 0));
        send_request(make_req(CMD_ADD, 1, 0, 1, 0, 0));
        send_request(make_req(CMD_COUNT, 0, 0, 0, 0, TS_MAX));
        send_request(make_req(CMD_COUNT, 0, 0, 0, 1, 1));
        send_request(make_req(CMD_COUNT, 0, 16'hFFFF, 0, TS_MAX, TS_MAX));
        // inverted window
        send_request(make_req(CMD_COUNT, 0, 0, 0, 1, 0));
        send_request(make_req(CMD_COUNT, 0, 0, 0, 2, TS_MAX));
        send_request(make_req(CMD_UNUSED, 16'hFFFF, 16'hFFFF, TS_MAX, TS_MAX, TS_MAX));
        // timestamp going backwards is still stored and counted
        send_request(make_req(CMD_ADD, 5, 5, 0, 0, 0));
        send_request(make_req(CMD_COUNT, 0, 5, 0, 0, 0));
        repeat (6) send_request(make_req(CMD_FWD, 0, 0, 0, 0, 0));
    endtask

    task automatic test_limit_settings();
        // zero acts as a limit of one
        write_limit(7'd0);
        send_request(make_req(CMD_ADD, 1, 2, 10, 0, 0));
        send_request(make_req(CMD_ADD, 3, 4, 11, 0, 0));
        send_request(make_req(CMD_COUNT, 0, 2, 0, 0, TS_MAX));
        send_request(make_req(CMD_FWD, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_FWD, 0, 0, 0, 0, 0));
        // above the depth, then lowered below the occupancy
        write_limit(7'd127);
        for (int i = 0; i < 6; i++)
            send_request(make_req(CMD_ADD, 16'(i), 9, 30'(20 + i), 0, 0));
        write_limit(7'd2);
        send_request(make_req(CMD_ADD, 7, 9, 40, 0, 0));
        send_request(make_req(CMD_COUNT, 0, 9, 0, 0, TS_MAX));
        repeat (3) send_request(make_req(CMD_FWD, 0, 0, 0, 0, 0));
        // duplicate at a full fifo evicts nothing
        write_limit(7'd1);
        send_request(make_req(CMD_ADD, 8, 8, 50, 0, 0));
        send_request(make_req(CMD_ADD, 8, 8, 50, 0, 0));
        send_request(make_req(CMD_COUNT, 0, 8, 0, 50, 50));
        send_request(make_req(CMD_FWD, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_phase(input logic [CAP_W-1:0] limit, input int unsigned idle_pct,
                                     input int unsigned stall_pct, input logic [29:0] ts_base,
                                     input int unsigned items);
        write_limit(limit);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        ts_clock      = ts_base;
        for (int n = 0; n < items; n++) begin
            // let all pending results drain now and then
            if (n % 70 == 69)
                wait_for_idle();
            send_request(random_request());
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_commands();
        test_limit_settings();
        test_random_phase(7'd64, 0, 0, 30'd0, 160);
        test_random_phase(7'($urandom_range(1, 6)), 50, 0, 30'd1000, 160);
        test_random_phase(7'($urandom_range(7, 63)), 0, 50, 30'd200000, 160);
        test_random_phase(7'd127, 6, 6, 30'($urandom_range(0, 30'h3FFF_0000)), 160);
        test_random_phase(7'($urandom_range(0, 127)), 6, 6, TS_MAX - 30'd1000, 160);
        wait_for_idle();
        repeat (80) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/pfdrc_pkg.sv
design/pfdrc_ram.sv
design/pfdrc_scan.sv
design/packet_fifo_dedup_range_count.sv
sim/packet_fifo_dedup_range_count_test.sv
